@@ sv/numa_timestamp_lock_arbiter_macros.svh @@
// Assertion macros used by the checker file of the lock arbiter.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef NUMA_TIMESTAMP_LOCK_ARBITER_MACROS_SVH
`define NUMA_TIMESTAMP_LOCK_ARBITER_MACROS_SVH

// Same-cycle implication.
`define NTLA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ntla_pkg.sv @@
package ntla_pkg;

  localparam int unsigned CORE_ID_W = 6;
  localparam int unsigned TIME_W    = 62;
  localparam int unsigned BATCH_W   = 8;
  localparam int unsigned STATUS_W  = 3;

  localparam logic [BATCH_W-1:0] BATCH_LIMIT_RESET = 8'd64;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_HANDED  = 3'd2,
    ST_FREED   = 3'd3,
    ST_ERROR   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_SOC,
    S_SCAN_ALL,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic latch;
    logic acq_grant;
    logic acq_queue;
    logic rel_error;
    logic scan_start;
    logic scan_global;
    logic hand_soc;
    logic hand_all;
    logic free_lock;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_rel;
    logic held;
    logic batch_ok;
    logic scan_done;
    logic best_valid;
  } dp_stat_t;

endpackage

@@ sv/ntla_if.sv @@
interface ntla_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [ntla_pkg::CORE_ID_W-1:0]   core_id;
  logic [ntla_pkg::TIME_W-1:0]      arrival_time;

  modport source (output valid, mode, core_id, arrival_time, input ready);
  modport sink (input valid, mode, core_id, arrival_time, output ready);
endinterface

interface ntla_out_if;
  logic                             valid;
  logic                             ready;
  logic [ntla_pkg::STATUS_W-1:0]    status;
  logic [ntla_pkg::CORE_ID_W-1:0]   grantee;
  logic                             same_socket;

  modport source (output valid, status, grantee, same_socket, input ready);
  modport sink (input valid, status, grantee, same_socket, output ready);
endinterface

@@ sv/numa_timestamp_lock_arbiter.sv @@
// Arbiter for one lock shared by cores grouped into sockets of SOCKET_SIZE consecutive core
// numbers. The block works on one item at a time: an item is taken when the block is idle,
// even while the previous result still waits in the output register. An acquire, and a release
// while the lock is free, sets its result in the execute state and loads it into the output
// register in the result state, and the block takes the next item only once it is idle again.
// A release walks the waiting times through the single read port of the wait-time memory, one
// core per cycle with one comparator. A handoff within the session socket is loaded after the
// pass over that socket. When the batch is spent the socket pass is skipped, and the result
// comes from the pass over all NUM_CORES cores. When the session socket has no waiter, that
// pass follows the socket pass. A full output register holds the block until its result
// moves on. The batch limit register may be written only while the block is idle.
module numa_timestamp_lock_arbiter #(
  parameter int unsigned NUM_CORES   = 64,
  parameter int unsigned SOCKET_SIZE = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ntla_pkg::BATCH_W-1:0] cfg_wdata_i,
  ntla_in_if.sink                      in_i,
  ntla_out_if.source                   out_o
);

  ntla_pkg::dp_cmd_t  cmd;
  ntla_pkg::dp_stat_t stat;

  ntla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ntla_dp #(
    .NUM_CORES   (NUM_CORES),
    .SOCKET_SIZE (SOCKET_SIZE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_mode_i         (in_i.mode),
    .in_core_id_i      (in_i.core_id),
    .in_arrival_time_i (in_i.arrival_time),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_status_o      (out_o.status),
    .out_grantee_o     (out_o.grantee),
    .out_same_socket_o (out_o.same_socket)
  );

endmodule

@@ sv/ntla_ctrl.sv @@
module ntla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ntla_pkg::dp_stat_t stat_i,
  output ntla_pkg::dp_cmd_t  cmd_o
);

  ntla_pkg::state_e  state_q, state_d;
  ntla_pkg::dp_cmd_t cmd;
  logic              out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntla_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ntla_pkg::S_EXEC;
      end
      ntla_pkg::S_EXEC: begin
        if (!stat_i.mode_rel || !stat_i.held) begin
          state_d = ntla_pkg::S_RESULT;
        end else if (stat_i.batch_ok) begin
          state_d = ntla_pkg::S_SCAN_SOC;
        end else begin
          state_d = ntla_pkg::S_SCAN_ALL;
        end
      end
      ntla_pkg::S_SCAN_SOC: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.best_valid ? ntla_pkg::S_RESULT : ntla_pkg::S_SCAN_ALL;
        end
      end
      ntla_pkg::S_SCAN_ALL: begin
        if (stat_i.scan_done) state_d = ntla_pkg::S_RESULT;
      end
      ntla_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) state_d = ntla_pkg::S_IDLE;
      end
      default: state_d = ntla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_q)
      ntla_pkg::S_IDLE: begin
        cmd.latch = in_valid_i;
      end
      ntla_pkg::S_EXEC: begin
        if (!stat_i.mode_rel) begin
          cmd.acq_grant = !stat_i.held;
          cmd.acq_queue = stat_i.held;
        end else if (!stat_i.held) begin
          cmd.rel_error = 1'b1;
        end else begin
          cmd.scan_start  = 1'b1;
          cmd.scan_global = !stat_i.batch_ok;
        end
      end
      ntla_pkg::S_SCAN_SOC: begin
        if (stat_i.scan_done) begin
          if (stat_i.best_valid) begin
            cmd.hand_soc = 1'b1;
          end else begin
            cmd.scan_start  = 1'b1;
            cmd.scan_global = 1'b1;
          end
        end
      end
      ntla_pkg::S_SCAN_ALL: begin
        if (stat_i.scan_done) begin
          cmd.hand_all  = stat_i.best_valid;
          cmd.free_lock = !stat_i.best_valid;
        end
      end
      ntla_pkg::S_RESULT: begin
        cmd.out_load = !out_valid_q || out_ready_i;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntla_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ntla_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

@@ sv/ntla_dp.sv @@
module ntla_dp #(
  parameter int unsigned NUM_CORES   = 64,
  parameter int unsigned SOCKET_SIZE = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ntla_pkg::BATCH_W-1:0]     cfg_wdata_i,
  input  logic                             in_mode_i,
  input  logic [ntla_pkg::CORE_ID_W-1:0]   in_core_id_i,
  input  logic [ntla_pkg::TIME_W-1:0]      in_arrival_time_i,
  input  ntla_pkg::dp_cmd_t                cmd_i,
  output ntla_pkg::dp_stat_t               stat_o,
  output logic [ntla_pkg::STATUS_W-1:0]    out_status_o,
  output logic [ntla_pkg::CORE_ID_W-1:0]   out_grantee_o,
  output logic                             out_same_socket_o
);

  localparam int unsigned CoreW      = $clog2(NUM_CORES);
  localparam int unsigned NumSockets = (NUM_CORES + SOCKET_SIZE - 1) / SOCKET_SIZE;
  localparam int unsigned SockW      = (NumSockets > 1) ? $clog2(NumSockets) : 1;
  localparam int unsigned CidW       = ntla_pkg::CORE_ID_W;
  localparam int unsigned TimeW      = ntla_pkg::TIME_W;
  localparam int unsigned BatchW     = ntla_pkg::BATCH_W;
  localparam int unsigned StatW      = ntla_pkg::STATUS_W;
  localparam logic [CoreW-1:0] LastCore = CoreW'(NUM_CORES - 1);

  // Restoring subtraction, one step per bit of the incoming core id.
  function automatic logic [CoreW-1:0] reduce_core(input logic [CidW-1:0] v);
    int r;
    r = int'(v);
    for (int k = CidW - 1; k >= 0; k--) begin
      if (r >= (NUM_CORES << k)) r = r - (NUM_CORES << k);
    end
    return CoreW'(r);
  endfunction

  function automatic logic [SockW-1:0] socket_of(input logic [CoreW-1:0] c);
    int r;
    int q;
    r = int'(c);
    q = 0;
    for (int k = CoreW - 1; k >= 0; k--) begin
      if (r >= (SOCKET_SIZE << k)) begin
        r = r - (SOCKET_SIZE << k);
        q = q + (1 << k);
      end
    end
    return SockW'(q);
  endfunction

  logic                 held_q;
  logic [NUM_CORES-1:0] flags_q;
  logic [SockW-1:0]     session_q;
  logic [BatchW-1:0]    batch_q;
  logic [BatchW-1:0]    limit_q;

  logic                 mode_q;
  logic [CoreW-1:0]     core_q;
  logic [TimeW-1:0]     time_q;

  logic [TimeW-1:0]     mem_q [NUM_CORES];

  logic                 issuing_q;
  logic [CoreW-1:0]     scan_idx_q;
  logic [CoreW-1:0]     scan_last_q;
  logic                 rd_valid_q;
  logic [CoreW-1:0]     rd_idx_q;
  logic [TimeW-1:0]     rd_data_q;
  logic                 best_valid_q;
  logic [CoreW-1:0]     best_idx_q;
  logic [TimeW-1:0]     best_time_q;

  logic [StatW-1:0]     res_status_q;
  logic [CidW-1:0]      res_grantee_q;
  logic                 res_same_q;
  logic [StatW-1:0]     out_status_q;
  logic [CidW-1:0]      out_grantee_q;
  logic                 out_same_q;

  logic [CoreW-1:0]     soc_lo;
  logic [CoreW-1:0]     soc_last;
  logic                 take;

  always_comb begin
    int lo;
    int hi;
    lo = int'(session_q) * SOCKET_SIZE;
    hi = lo + SOCKET_SIZE;
    if (hi > NUM_CORES) hi = NUM_CORES;
    soc_lo   = CoreW'(lo);
    soc_last = CoreW'(hi - 1);
  end

  assign take = rd_valid_q && flags_q[rd_idx_q] &&
                (!best_valid_q || (rd_data_q < best_time_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= 1'b0;
      flags_q      <= '0;
      session_q    <= '0;
      batch_q      <= '0;
      limit_q      <= ntla_pkg::BATCH_LIMIT_RESET;
      issuing_q    <= 1'b0;
      rd_valid_q   <= 1'b0;
      best_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.acq_grant) begin
        held_q    <= 1'b1;
        session_q <= socket_of(core_q);
        batch_q   <= '0;
      end
      if (cmd_i.acq_queue) flags_q[core_q] <= 1'b1;
      if (cmd_i.hand_soc) begin
        flags_q[best_idx_q] <= 1'b0;
        batch_q             <= batch_q + 1'b1;
      end
      if (cmd_i.hand_all) begin
        flags_q[best_idx_q] <= 1'b0;
        batch_q             <= '0;
        session_q           <= socket_of(best_idx_q);
      end
      if (cmd_i.free_lock) held_q <= 1'b0;
      if (cmd_i.scan_start) begin
        issuing_q    <= 1'b1;
        rd_valid_q   <= 1'b0;
        best_valid_q <= 1'b0;
      end else begin
        rd_valid_q <= issuing_q;
        if (issuing_q && (scan_idx_q == scan_last_q)) issuing_q <= 1'b0;
        if (take) best_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acq_queue) mem_q[core_q] <= time_q;
    rd_data_q <= mem_q[scan_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= in_mode_i;
      core_q <= reduce_core(in_core_id_i);
      time_q <= in_arrival_time_i;
    end
    if (cmd_i.scan_start) begin
      scan_idx_q  <= cmd_i.scan_global ? '0 : soc_lo;
      scan_last_q <= cmd_i.scan_global ? LastCore : soc_last;
    end else if (issuing_q) begin
      scan_idx_q <= scan_idx_q + 1'b1;
    end
    rd_idx_q <= scan_idx_q;
    if (!cmd_i.scan_start && take) begin
      best_idx_q  <= rd_idx_q;
      best_time_q <= rd_data_q;
    end
    if (cmd_i.acq_grant) begin
      res_status_q  <= ntla_pkg::ST_GRANTED;
      res_grantee_q <= CidW'(core_q);
      res_same_q    <= 1'b0;
    end
    if (cmd_i.acq_queue) begin
      res_status_q  <= ntla_pkg::ST_QUEUED;
      res_grantee_q <= '0;
      res_same_q    <= 1'b0;
    end
    if (cmd_i.rel_error) begin
      res_status_q  <= ntla_pkg::ST_ERROR;
      res_grantee_q <= '0;
      res_same_q    <= 1'b0;
    end
    if (cmd_i.hand_soc || cmd_i.hand_all) begin
      res_status_q  <= ntla_pkg::ST_HANDED;
      res_grantee_q <= CidW'(best_idx_q);
      res_same_q    <= cmd_i.hand_soc;
    end
    if (cmd_i.free_lock) begin
      res_status_q  <= ntla_pkg::ST_FREED;
      res_grantee_q <= '0;
      res_same_q    <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_grantee_q <= res_grantee_q;
      out_same_q    <= res_same_q;
    end
  end

  assign stat_o.mode_rel   = (mode_q == ntla_pkg::MODE_RELEASE);
  assign stat_o.held       = held_q;
  assign stat_o.batch_ok   = (batch_q < limit_q);
  assign stat_o.scan_done  = !issuing_q && !rd_valid_q;
  assign stat_o.best_valid = best_valid_q;

  assign out_status_o      = out_status_q;
  assign out_grantee_o     = out_grantee_q;
  assign out_same_socket_o = out_same_q;

endmodule

@@ sv/ntla_checker.sv @@
`include "numa_timestamp_lock_arbiter_macros.svh"

module ntla_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [ntla_pkg::STATUS_W-1:0]    out_status_i,
  input logic [ntla_pkg::CORE_ID_W-1:0]   out_grantee_i,
  input logic                             out_same_socket_i
);

  logic grant_kind;
  logic handed;

  assign grant_kind = (out_status_i == ntla_pkg::ST_GRANTED) ||
                      (out_status_i == ntla_pkg::ST_HANDED);
  assign handed     = (out_status_i == ntla_pkg::ST_HANDED);

  // A result stays offered until its transfer.
  `NTLA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  // The block works on one item at a time.
  `NTLA_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i, "second item taken")
  // Only a grant or a handoff names a grantee.
  `NTLA_ASSERT_SAME(a_grantee, out_valid_i && !grant_kind, out_grantee_i == '0, "stray grantee")
  // The same-socket flag marks only a handoff.
  `NTLA_ASSERT_SAME(a_same, out_valid_i && out_same_socket_i, handed, "stray same_socket")

endmodule

bind numa_timestamp_lock_arbiter ntla_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_grantee_i     (out_o.grantee),
  .out_same_socket_i (out_o.same_socket)
);
